FILE: rtl/core/calendar_date_adder_defines.svh
// Assertion macros shared by the checker of the calendar date adder.
// The macros expect signals named clk and rst in the scope where they are used.
`ifndef CALENDAR_DATE_ADDER_DEFINES_SVH
`define CALENDAR_DATE_ADDER_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define CDA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define CDA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define CDA_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/cda_pkg.sv
// Package of the calendar date adder: widths, codes, calendar tables and the microprogram.
// Depends on nothing; used by the top level, its checker and the testbench.
package cda_pkg;

  localparam int MAX_YEAR   = 9999;
  localparam int AMT_W      = 15;
  localparam int AMT_MAX    = 2 ** AMT_W - 1;
  localparam int YEAR_IN_W  = 14;
  localparam int YEAR_W     = $clog2(MAX_YEAR + AMT_MAX + 1);
  localparam int N_W        = $clog2(AMT_MAX * 7 + 1);
  localparam int LEAP_CYCLE = 400;
  localparam int Q_W        = $clog2(LEAP_CYCLE);
  localparam int PC_W       = 4;

  localparam logic [3:0] DEC        = 4'd12;
  localparam logic [3:0] JAN        = 4'd1;
  localparam logic [3:0] FEB        = 4'd2;
  localparam logic [4:0] FEB_LEAP   = 5'd29;
  localparam logic [4:0] FEB_COMMON = 5'd28;
  localparam logic [3:0] MON_PER_YEAR = 4'd12;

  localparam logic [4:0] MONTH_LEN [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                           5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  localparam logic [2:0] CMD_DAYS   = 3'd0;
  localparam logic [2:0] CMD_WEEKS  = 3'd1;
  localparam logic [2:0] CMD_MONTHS = 3'd2;
  localparam logic [2:0] CMD_YSTEP  = 3'd3;
  localparam logic [2:0] CMD_YDIR   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef logic [3:0]      op_t;
  typedef logic [3:0]      cond_t;
  typedef logic [PC_W-1:0] pc_t;

  localparam op_t OP_NOP   = 4'd0;
  localparam op_t OP_LOAD  = 4'd1;
  localparam op_t OP_MOD   = 4'd2;
  localparam op_t OP_CHECK = 4'd3;
  localparam op_t OP_DAY   = 4'd4;
  localparam op_t OP_MON12 = 4'd5;
  localparam op_t OP_MON1  = 4'd6;
  localparam op_t OP_YSTEP = 4'd7;
  localparam op_t OP_YADD  = 4'd8;
  localparam op_t OP_CLAMP = 4'd9;
  localparam op_t OP_OVF   = 4'd10;
  localparam op_t OP_FIN   = 4'd11;

  localparam cond_t C_NONE     = 4'd0;
  localparam cond_t C_ALWAYS   = 4'd1;
  localparam cond_t C_WAIT_IN  = 4'd2;
  localparam cond_t C_Q_GE     = 4'd3;
  localparam cond_t C_INVALID  = 4'd4;
  localparam cond_t C_DISPATCH = 4'd5;
  localparam cond_t C_N_NZ     = 4'd6;
  localparam cond_t C_N_GE12   = 4'd7;
  localparam cond_t C_OUT_BUSY = 4'd8;

  localparam pc_t P_IDLE   = 4'd0;
  localparam pc_t P_MOD    = 4'd1;
  localparam pc_t P_CHECK  = 4'd2;
  localparam pc_t P_DISP   = 4'd3;
  localparam pc_t P_DAYS   = 4'd4;
  localparam pc_t P_DAYS_X = 4'd5;
  localparam pc_t P_MON12  = 4'd6;
  localparam pc_t P_MON1   = 4'd7;
  localparam pc_t P_MON_X  = 4'd8;
  localparam pc_t P_YSTEP  = 4'd9;
  localparam pc_t P_YDIR   = 4'd10;
  localparam pc_t P_YMOD   = 4'd11;
  localparam pc_t P_CLAMP  = 4'd12;
  localparam pc_t P_SPARE  = 4'd13;
  localparam pc_t P_OVF    = 4'd14;
  localparam pc_t P_FIN    = 4'd15;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // Leap test on the year reduced modulo the 400-year cycle.
  function automatic logic is_leap(input logic [Q_W-1:0] q);
    return (q[1:0] == 2'd0) && (q != Q_W'(100)) && (q != Q_W'(200)) && (q != Q_W'(300));
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m == FEB) begin
      len = leap ? FEB_LEAP : FEB_COMMON;
    end else if (m >= JAN && m <= DEC) begin
      len = MONTH_LEN[m - 4'd1];
    end else begin
      len = 5'd0;
    end
    return len;
  endfunction

  function automatic pc_t dispatch(input logic [2:0] cmd);
    pc_t t;
    case (cmd)
      CMD_DAYS, CMD_WEEKS: t = P_DAYS;
      CMD_MONTHS:          t = P_MON12;
      CMD_YSTEP:           t = P_YSTEP;
      CMD_YDIR:            t = P_YDIR;
      default:             t = P_OVF;
    endcase
    return t;
  endfunction

  // When a jump is not taken the step counter moves to the next word.
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      P_IDLE:   w = '{OP_LOAD,  C_WAIT_IN,  P_IDLE};
      P_MOD:    w = '{OP_MOD,   C_Q_GE,     P_MOD};
      P_CHECK:  w = '{OP_CHECK, C_INVALID,  P_FIN};
      P_DISP:   w = '{OP_NOP,   C_DISPATCH, P_IDLE};
      P_DAYS:   w = '{OP_DAY,   C_N_NZ,     P_DAYS};
      P_DAYS_X: w = '{OP_NOP,   C_ALWAYS,   P_OVF};
      P_MON12:  w = '{OP_MON12, C_N_GE12,   P_MON12};
      P_MON1:   w = '{OP_MON1,  C_N_NZ,     P_MON1};
      P_MON_X:  w = '{OP_NOP,   C_ALWAYS,   P_OVF};
      P_YSTEP:  w = '{OP_YSTEP, C_ALWAYS,   P_OVF};
      P_YDIR:   w = '{OP_YADD,  C_NONE,     P_IDLE};
      P_YMOD:   w = '{OP_MOD,   C_Q_GE,     P_YMOD};
      P_CLAMP:  w = '{OP_CLAMP, C_ALWAYS,   P_OVF};
      P_OVF:    w = '{OP_OVF,   C_NONE,     P_IDLE};
      P_FIN:    w = '{OP_FIN,   C_OUT_BUSY, P_FIN};
      default:  w = '{OP_NOP,   C_ALWAYS,   P_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/calendar_date_adder.sv
// Top level of the calendar date adder: a microcoded sequencer over a small date datapath.
// Depends on cda_pkg for widths, codes, calendar tables and the microprogram.
//
// Usage: one input word on the s_axis channel carries a command, an amount and a
// starting date; one output word on the m_axis channel carries the resulting date and a
// status (ok, invalid input date or year overflow; on either error the input date is echoed).
// Words move when tvalid and tready are both high. One item is worked at a time:
// s_axis_tready is high only while the sequencer waits in its idle step.
// After acceptance the sequencer reduces year_in modulo 400 for the leap cycle, checks
// the date, dispatches on the command and runs the command loop:
//   days and weeks: one month boundary crossed per loop step;
//   months: whole years of twelve months first, then single months;
//   years stepwise: one addition; years direct: addition, reduction modulo 400, clamp.
// A year overflow check follows. The day loop of the sequencer sets the worst case.
// The result sits in an output register; the next item is accepted while it waits.
// If the receiver stalls and a second result is ready, the sequencer holds in its
// final step until the output register is free.
// Reset returns the sequencer to its idle step and drops m_axis_tvalid.
module calendar_date_adder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // amount, day_in, month_in, year_in, zero fill
  input  logic [2:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // day_out, month_out, year_out, zero fill
  output logic [1:0]  m_axis_tuser    // status
);

  localparam int YW = cda_pkg::YEAR_W;
  localparam int NW = cda_pkg::N_W;
  localparam int QW = cda_pkg::Q_W;
  localparam int YIW = cda_pkg::YEAR_IN_W;

  logic [2:0]     cmd;
  logic [14:0]    amount;
  logic [4:0]     day_in;
  logic [3:0]     month_in;
  logic [YIW-1:0] year_in;

  assign amount   = s_axis_tdata[14:0];
  assign day_in   = s_axis_tdata[19:15];
  assign month_in = s_axis_tdata[23:20];
  assign year_in  = s_axis_tdata[37:24];
  assign cmd      = s_axis_tuser;

  cda_pkg::pc_t    pc;
  cda_pkg::pc_t    pc_next;
  cda_pkg::uword_t cw;

  logic [2:0]     cmd_r;
  logic [NW-1:0]  n;
  logic [4:0]     d;
  logic [3:0]     m;
  logic [YW-1:0]  y;
  logic [YW-1:0]  q;
  logic [1:0]     st;
  logic [4:0]     d0;
  logic [3:0]     m0;
  logic [YIW-1:0] y0;

  logic [4:0]     out_day;
  logic [3:0]     out_month;
  logic [YIW-1:0] out_year;
  logic [1:0]     out_status;

  logic          leap_cur;
  logic          leap_nxt;
  logic [QW-1:0] q_inc9;
  logic [YW-1:0] q_inc;
  logic [4:0]    len_cur;
  logic [4:0]    left;
  logic [3:0]    m_adv;
  logic [YW-1:0] y_adv;
  logic [YW-1:0] q_adv;
  logic [4:0]    len_adv;
  logic [4:0]    feb_len;
  logic [YW-1:0] y_sum;
  logic          q_ge;
  logic          invalid;
  logic          n_nz;
  logic          n_ge12;
  logic          out_busy;
  logic          out_load;
  logic          cond_hit;

  assign cw = cda_pkg::ucode(pc);

  assign leap_cur = cda_pkg::is_leap(q[QW-1:0]);
  assign q_inc9   = (q[QW-1:0] == QW'(cda_pkg::LEAP_CYCLE - 1)) ? '0 : q[QW-1:0] + 1'b1;
  assign q_inc    = YW'(q_inc9);
  assign leap_nxt = cda_pkg::is_leap(q_inc9);
  assign len_cur  = cda_pkg::month_days(m, leap_cur);
  assign left     = len_cur - d;
  assign m_adv    = (m == cda_pkg::DEC) ? cda_pkg::JAN : m + 4'd1;
  assign y_adv    = (m == cda_pkg::DEC) ? y + 1'b1 : y;
  assign q_adv    = (m == cda_pkg::DEC) ? q_inc : q;
  assign len_adv  = cda_pkg::month_days(m_adv, leap_cur);
  assign y_sum    = y + YW'(n);

  // A full year of months from January passes this year's February, otherwise next year's.
  assign feb_len = (m == cda_pkg::JAN) ?
                   (leap_cur ? cda_pkg::FEB_LEAP : cda_pkg::FEB_COMMON) :
                   (leap_nxt ? cda_pkg::FEB_LEAP : cda_pkg::FEB_COMMON);

  assign q_ge    = q >= YW'(cda_pkg::LEAP_CYCLE);
  assign invalid = (len_cur == 5'd0) || (d == 5'd0) || (d > len_cur) ||
                   (y == '0) || (y > YW'(cda_pkg::MAX_YEAR));
  assign n_nz    = n != '0;
  assign n_ge12  = n >= NW'(cda_pkg::MON_PER_YEAR);

  assign out_busy = m_axis_tvalid && !m_axis_tready;
  assign out_load = (cw.op == cda_pkg::OP_FIN) && !out_busy;

  assign s_axis_tready = (pc == cda_pkg::P_IDLE);

  always_comb begin
    case (cw.cond)
      cda_pkg::C_NONE:     cond_hit = 1'b0;
      cda_pkg::C_ALWAYS:   cond_hit = 1'b1;
      cda_pkg::C_WAIT_IN:  cond_hit = !s_axis_tvalid;
      cda_pkg::C_Q_GE:     cond_hit = q_ge;
      cda_pkg::C_INVALID:  cond_hit = invalid;
      cda_pkg::C_N_NZ:     cond_hit = n_nz;
      cda_pkg::C_N_GE12:   cond_hit = n_ge12;
      cda_pkg::C_OUT_BUSY: cond_hit = out_busy;
      default:             cond_hit = 1'b0;
    endcase
    if (cw.cond == cda_pkg::C_DISPATCH) begin
      pc_next = cda_pkg::dispatch(cmd_r);
    end else if (cond_hit) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= cda_pkg::P_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    case (cw.op)
      cda_pkg::OP_LOAD: begin
        if (s_axis_tvalid) begin
          cmd_r <= cmd;
          d     <= day_in;
          m     <= month_in;
          y     <= YW'(year_in);
          q     <= YW'(year_in);
          d0    <= day_in;
          m0    <= month_in;
          y0    <= year_in;
          st    <= cda_pkg::ST_OK;
          if (cmd == cda_pkg::CMD_WEEKS) begin
            n <= NW'({amount, 3'b000}) - NW'(amount);
          end else begin
            n <= NW'(amount);
          end
        end
      end
      cda_pkg::OP_MOD: begin
        if (q_ge) begin
          q <= q - YW'(cda_pkg::LEAP_CYCLE);
        end
      end
      cda_pkg::OP_CHECK: begin
        st <= invalid ? cda_pkg::ST_INVALID : cda_pkg::ST_OK;
      end
      cda_pkg::OP_DAY: begin
        if (n <= NW'(left)) begin
          d <= d + n[4:0];
          n <= '0;
        end else begin
          n <= n - NW'(left) - 1'b1;
          d <= 5'd1;
          m <= m_adv;
          y <= y_adv;
          q <= q_adv;
        end
      end
      cda_pkg::OP_MON12: begin
        if (n_ge12) begin
          n <= n - NW'(cda_pkg::MON_PER_YEAR);
          y <= y + 1'b1;
          q <= q_inc;
          if (d > feb_len) begin
            d <= feb_len;
          end
        end
      end
      cda_pkg::OP_MON1: begin
        if (n_nz) begin
          n <= n - 1'b1;
          m <= m_adv;
          y <= y_adv;
          q <= q_adv;
          if (d > len_adv) begin
            d <= len_adv;
          end
        end
      end
      cda_pkg::OP_YSTEP: begin
        y <= y_sum;
        // The year after a leap year is common, so a leap day is lost at the first step.
        if (n_nz && m == cda_pkg::FEB && d == cda_pkg::FEB_LEAP) begin
          d <= cda_pkg::FEB_COMMON;
        end
      end
      cda_pkg::OP_YADD: begin
        y <= y_sum;
        q <= y_sum;
      end
      cda_pkg::OP_CLAMP: begin
        if (d > len_cur) begin
          d <= len_cur;
        end
      end
      cda_pkg::OP_OVF: begin
        if (y > YW'(cda_pkg::MAX_YEAR)) begin
          st <= cda_pkg::ST_OVERFLOW;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= st;
      if (st != cda_pkg::ST_OK) begin
        out_day   <= d0;
        out_month <= m0;
        out_year  <= y0;
      end else begin
        out_day   <= d;
        out_month <= m;
        out_year  <= y[YIW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {1'b0, out_year, out_month, out_day};
  assign m_axis_tuser = out_status;

endmodule

FILE: rtl/core/cda_checker.sv
// Port-level checker for the calendar date adder, bound to the top level.
// Depends on cda_pkg and the assertion macros in calendar_date_adder_defines.svh.
`include "calendar_date_adder_defines.svh"

module cda_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic ok_word;
  logic ok_date;

  assign ok_word = m_axis_tvalid && (m_axis_tuser == cda_pkg::ST_OK);
  assign ok_date = (m_axis_tdata[4:0] != 5'd0) && (m_axis_tdata[8:5] != 4'd0) &&
                   (m_axis_tdata[8:5] <= cda_pkg::DEC) && (m_axis_tdata[22:9] != '0);

  `CDA_ASSERT_RST(a_reset_idle, rst, !m_axis_tvalid, "output valid after reset")
  `CDA_ASSERT_IMP(a_status_code, m_axis_tvalid, m_axis_tuser == cda_pkg::ST_OK || m_axis_tuser == cda_pkg::ST_INVALID || m_axis_tuser == cda_pkg::ST_OVERFLOW, "undefined status")
  `CDA_ASSERT_IMP(a_ok_date, ok_word, ok_date, "ok result with a malformed date")
  `CDA_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
  `CDA_ASSERT_NXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled word changed")

endmodule

bind calendar_date_adder cda_checker u_cda_checker (.*);

FILE: tb/calendar_date_adder_tb.sv
// Testbench of the calendar date adder: drives dates, commands and amounts over the input
// stream and checks each output word against a date predictor held in a scoreboard class.
// Depends on cda_pkg and the calendar_date_adder top level.
`timescale 1ns / 1ps

module calendar_date_adder_tb;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int LONG_STALL  = 400;

  typedef struct {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [1:0]  status;
  } date_result_t;

  function automatic bit leap_year(int y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int month_length(int m, int y);
    int lengths [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m < 1 || m > 12) begin
      return 0;
    end
    if (m == 2) begin
      return leap_year(y) ? 29 : 28;
    end
    return lengths[m - 1];
  endfunction

  class date_scoreboard;
    date_result_t expected_q[$];
    int errors;
    int checked;
    int ok_count;
    int invalid_count;
    int overflow_count;

    function date_result_t advance_date(logic [2:0] cmd, logic [14:0] amount, logic [4:0] d0,
                                        logic [3:0] m0, logic [13:0] y0);
      date_result_t r;
      int d, m, y, n, left;
      d = int'(d0);
      m = int'(m0);
      y = int'(y0);
      n = int'(amount);
      r.status = cda_pkg::ST_OK;
      if (m < 1 || m > 12 || d < 1 || d > month_length(m, y) || y < 1 ||
          y > cda_pkg::MAX_YEAR) begin
        r.status = cda_pkg::ST_INVALID;
      end else begin
        case (cmd)
          cda_pkg::CMD_DAYS, cda_pkg::CMD_WEEKS: begin
            if (cmd == cda_pkg::CMD_WEEKS) begin
              n = n * 7;
            end
            while (n > 0) begin
              left = month_length(m, y) - d;
              if (n <= left) begin
                d = d + n;
                n = 0;
              end else begin
                n = n - (left + 1);
                d = 1;
                if (m == 12) begin
                  m = 1;
                  y++;
                end else begin
                  m++;
                end
              end
            end
          end
          cda_pkg::CMD_MONTHS: begin
            for (int i = 0; i < n; i++) begin
              if (m == 12) begin
                m = 1;
                y++;
              end else begin
                m++;
              end
              if (d > month_length(m, y)) begin
                d = month_length(m, y);
              end
            end
          end
          cda_pkg::CMD_YSTEP: begin
            for (int i = 0; i < n; i++) begin
              y++;
              if (d > month_length(m, y)) begin
                d = month_length(m, y);
              end
            end
          end
          cda_pkg::CMD_YDIR: begin
            y = y + n;
            if (d > month_length(m, y)) begin
              d = month_length(m, y);
            end
          end
          default: begin
          end
        endcase
        if (y > cda_pkg::MAX_YEAR) begin
          r.status = cda_pkg::ST_OVERFLOW;
        end
      end
      if (r.status != cda_pkg::ST_OK) begin
        d = int'(d0);
        m = int'(m0);
        y = int'(y0);
      end
      r.day = d[4:0];
      r.month = m[3:0];
      r.year = y[13:0];
      return r;
    endfunction

    function void note_input(logic [2:0] cmd, logic [14:0] amount, logic [4:0] d0,
                             logic [3:0] m0, logic [13:0] y0);
      date_result_t r;
      r = advance_date(cmd, amount, d0, m0, y0);
      case (r.status)
        cda_pkg::ST_OK:      ok_count++;
        cda_pkg::ST_INVALID: invalid_count++;
        default:             overflow_count++;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [23:0] data, logic [1:0] status);
      date_result_t want;
      if (expected_q.size() == 0) begin
        $error("Output word %h with status %0d arrived with no date pending.", data, status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (data[4:0] !== want.day) begin
        $error("day_out: expected %0d, got %0d", want.day, data[4:0]);
        errors++;
      end
      if (data[8:5] !== want.month) begin
        $error("month_out: expected %0d, got %0d", want.month, data[8:5]);
        errors++;
      end
      if (data[22:9] !== want.year) begin
        $error("year_out: expected %0d, got %0d", want.year, data[22:9]);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // amount, day_in, month_in, year_in, zero fill
  logic [2:0]  s_axis_tuser = '0;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // day_out, month_out, year_out, zero fill
  logic [1:0]  m_axis_tuser;        // status

  date_scoreboard sb = new();
  int cycle_count = 0;
  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  bit hold_request = 1'b0;

  calendar_date_adder u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // The receiver samples the handshake at each edge, then decides its next tready.
  initial begin : sink
    int hold_left;
    hold_left = 0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tuser);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_STALL;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (int'($urandom_range(0, 99)) >= dst_idle_pct);
      end
    end
  end

  task automatic send_word(logic [2:0] cmd, logic [14:0] amount, logic [4:0] d,
                           logic [3:0] m, logic [13:0] y);
    while (int'($urandom_range(0, 99)) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, y, m, d, amount};
    s_axis_tuser <= cmd;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.note_input(cmd, amount, d, m, y);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly well-formed dates, often at month ends, with some wholly random words.
  task automatic send_random_word();
    logic [2:0]  cmd;
    logic [14:0] amount;
    logic [4:0]  d;
    logic [3:0]  m;
    logic [13:0] y;
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      cmd = 3'($urandom);
      amount = 15'($urandom);
      d = 5'($urandom);
      m = 4'($urandom);
      y = 14'($urandom);
    end else begin
      cmd = (pick < 17) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      m = 4'($urandom_range(1, 12));
      y = ($urandom_range(0, 9) == 0) ? 14'($urandom_range(9900, 9999))
                                      : 14'($urandom_range(1, 9999));
      len = month_length(int'(m), int'(y));
      d = ($urandom_range(0, 3) == 0) ? 5'(len) : 5'($urandom_range(1, len));
      amount = ($urandom_range(0, 19) == 0) ? 15'($urandom_range(16384, 32767))
                                            : 15'($urandom_range(0, 400));
    end
    send_word(cmd, amount, d, m, y);
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    src_idle_pct = 26;
    dst_idle_pct = 46;

    send_word(cda_pkg::CMD_DAYS,   15'd0,     5'd1,  4'd1,  14'd1);
    send_word(cda_pkg::CMD_DAYS,   15'd1,     5'd31, 4'd12, 14'd9999);
    send_word(cda_pkg::CMD_DAYS,   15'd1,     5'd28, 4'd2,  14'd2000);
    send_word(cda_pkg::CMD_DAYS,   15'd1,     5'd28, 4'd2,  14'd1900);
    send_word(cda_pkg::CMD_DAYS,   15'd32767, 5'd1,  4'd1,  14'd1);
    send_word(cda_pkg::CMD_WEEKS,  15'd32767, 5'd31, 4'd12, 14'd9000);
    send_word(cda_pkg::CMD_MONTHS, 15'd1,     5'd31, 4'd1,  14'd2023);
    send_word(cda_pkg::CMD_MONTHS, 15'd2,     5'd31, 4'd1,  14'd2024);
    send_word(cda_pkg::CMD_MONTHS, 15'd32767, 5'd15, 4'd6,  14'd1);
    send_word(cda_pkg::CMD_YSTEP,  15'd1,     5'd29, 4'd2,  14'd2024);
    send_word(cda_pkg::CMD_YSTEP,  15'd4,     5'd29, 4'd2,  14'd2020);
    send_word(cda_pkg::CMD_YSTEP,  15'd9998,  5'd1,  4'd1,  14'd1);
    send_word(cda_pkg::CMD_YDIR,   15'd4,     5'd29, 4'd2,  14'd2020);
    send_word(cda_pkg::CMD_YDIR,   15'd1,     5'd29, 4'd2,  14'd2020);
    send_word(cda_pkg::CMD_YDIR,   15'd32767, 5'd1,  4'd1,  14'd1);
    send_word(cda_pkg::CMD_YDIR,   15'd0,     5'd31, 4'd12, 14'd9999);
    send_word(cda_pkg::CMD_DAYS,   15'd5,     5'd10, 4'd0,  14'd2000);
    send_word(cda_pkg::CMD_DAYS,   15'd5,     5'd10, 4'd15, 14'd2000);
    send_word(cda_pkg::CMD_DAYS,   15'd5,     5'd0,  4'd3,  14'd2000);
    send_word(cda_pkg::CMD_DAYS,   15'd5,     5'd31, 4'd4,  14'd2000);
    send_word(cda_pkg::CMD_DAYS,   15'd5,     5'd29, 4'd2,  14'd2023);
    send_word(cda_pkg::CMD_DAYS,   15'd5,     5'd1,  4'd1,  14'd0);
    send_word(cda_pkg::CMD_DAYS,   15'd5,     5'd31, 4'd13, 14'd16383);
    send_word(3'd5,                15'd100,   5'd17, 4'd8,  14'd1984);
    send_word(3'd7,                15'd32767, 5'd31, 4'd12, 14'd9999);
    stop_sending();
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 46 : 0;
      dst_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 26 : 0;
      for (int i = 0; i < 25; i++) begin
        if (phase == 0 && i == 8) begin
          hold_request = 1'b1;
        end
        send_random_word();
      end
      stop_sending();
      wait_drained();
    end

    repeat (50) @(posedge clk);
    $display("Checked %0d words: %0d advanced, %0d invalid, %0d past the year limit.",
             sb.checked, sb.ok_count, sb.invalid_count, sb.overflow_count);
    $display("All five commands, unknown commands and both idling orders were exercised.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/cda_pkg.sv
rtl/core/calendar_date_adder.sv
rtl/core/cda_checker.sv
tb/calendar_date_adder_tb.sv
